>>> design/ddvr_pkg.sv
// ----------------------------------------------------------------------------
// ddvr_pkg
// Types and constants shared by the velocity ramp controller, datapath and
// register block.
// ----------------------------------------------------------------------------
package ddvr_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned TURN_W  = 14;
	localparam int unsigned EL_W    = 16;
	localparam int unsigned VEL_W   = 16;
	localparam int unsigned FREQ_W  = 18;
	localparam int unsigned STEP_W  = 13;
	localparam int unsigned MUL_W   = 29;
	localparam int unsigned PROD_W  = 2 * MUL_W;

	localparam int unsigned ACCEL_W = 16;
	localparam int unsigned MS_W    = 6;
	localparam int unsigned BAND_W  = 8;

	localparam logic [ACCEL_W-1:0] ACCEL_RST = 16'd4096;
	localparam logic [MS_W-1:0]    MS_RST    = 6'd32;
	localparam logic [BAND_W-1:0]  BAND_RST  = 8'd4;

	// exact reciprocals: floor(y/15625) and floor(y/21) for y below 2**27
	localparam logic [27:0] RECIP_STEP = 28'd140737489;
	localparam int unsigned SHIFT_STEP = 41;
	localparam logic [27:0] RECIP_FREQ = 28'd204522253;
	localparam int unsigned SHIFT_FREQ = 32;
	localparam logic [32:0] HALF_MEGA  = 33'd500000;

	typedef enum logic [2:0] {
		MUL_CMD_L,
		MUL_CMD_R,
		MUL_ACC,
		MUL_STEP,
		MUL_SCALE,
		MUL_FREQ_L,
		MUL_FREQ_R,
		MUL_RECIP
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     wr_lt;
		logic     wr_rt;
		logic     wr_vel;
		logic     wr_c;
		logic     wr_lf;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic turn_ok;
	} dp_stat_t;

	typedef struct packed {
		logic [ACCEL_W-1:0] accel_rate;
		logic [MS_W-1:0]    microsteps;
		logic [BAND_W-1:0]  settle_band;
	} cfg_t;

endpackage

>>> design/ddvr_regs.sv
// ----------------------------------------------------------------------------
// ddvr_regs
// Configuration register block behind an APB-style port.
// ----------------------------------------------------------------------------
module ddvr_regs import ddvr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	localparam logic [1:0] REG_ACCEL = 2'd0;
	localparam logic [1:0] REG_MS    = 2'd1;
	localparam logic [1:0] REG_BAND  = 2'd2;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_rate  <= ACCEL_RST;
			cfg_q.microsteps  <= MS_RST;
			cfg_q.settle_band <= BAND_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ACCEL: cfg_q.accel_rate  <= pwdata[ACCEL_W-1:0];
				REG_MS:    cfg_q.microsteps  <= pwdata[MS_W-1:0];
				REG_BAND:  cfg_q.settle_band <= pwdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ACCEL: prdata = 32'(cfg_q.accel_rate);
			REG_MS:    prdata = 32'(cfg_q.microsteps);
			REG_BAND:  prdata = 32'(cfg_q.settle_band);
			default:   prdata = 32'd0;
		endcase
	end

endmodule

>>> design/ddvr_dp.sv
// ----------------------------------------------------------------------------
// ddvr_dp
// Datapath: input and state registers, one shared multiplier with its product
// register, target rounding, velocity ramp and step frequency scaling.
// ----------------------------------------------------------------------------
module ddvr_dp import ddvr_pkg::*; #(
	parameter int unsigned STEPS_PER_TURN = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [47:0] s_tdata,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [39:0] m_tdata
);

	localparam int unsigned K_VAL = STEPS_PER_TURN * 100;
	localparam int unsigned KW    = $clog2(K_VAL + 1);
	localparam int unsigned CW    = MS_W + KW;
	localparam int unsigned YW    = VEL_W + CW - 12;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

	logic signed [SPEED_W-1:0] speed_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic [EL_W-1:0]           el_q;

	logic signed [VEL_W-1:0] lt_q, rt_q, lv_q, rv_q;
	logic                    lupd_q, rupd_q;
	logic [CW-1:0]           c_q;
	logic [FREQ_W-1:0]       lf_q;

	logic [FREQ_W-1:0] of_lf_q, of_rf_q;
	logic              of_ldir_q, of_lupd_q, of_rdir_q, of_rupd_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [TURN_W:0] k_l, k_r;
	logic [32:0]            step_sum;
	logic [STEP_W-1:0]      step;
	logic signed [VEL_W-1:0] nl, nr;
	logic [FREQ_W-1:0]      freq;
	logic                   speed_zero;

	function automatic logic signed [VEL_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
		logic signed [30:0] s;
		logic signed [18:0] r;
		s = $signed(p[30:0]) + 31'sd2048;
		r = $signed(s[30:12]);
		if (r > 19'sd32767)
			return 16'sh7fff;
		else if (r < -19'sd32768)
			return 16'sh8000;
		else
			return 16'(r);
	endfunction

	function automatic logic signed [VEL_W-1:0] ramp(
		input logic signed [VEL_W-1:0] tgt,
		input logic signed [VEL_W-1:0] vel,
		input logic [STEP_W-1:0]       st,
		input logic [BAND_W-1:0]       band
	);
		logic signed [16:0] diff;
		logic [16:0]        mag;
		logic signed [17:0] st_s;
		logic signed [17:0] nv;
		diff = 17'(tgt) - 17'(vel);
		mag  = (diff < 0) ? 17'(-diff) : 17'(diff);
		st_s = $signed({5'b0, st});
		if (mag <= 17'(band))
			return vel;
		if (tgt > vel) begin
			nv = 18'(vel) + st_s;
			if (nv > 18'(tgt))
				nv = 18'(tgt);
		end else begin
			nv = 18'(vel) - st_s;
			if (nv < 18'(tgt))
				nv = 18'(tgt);
		end
		return 16'(nv);
	endfunction

	function automatic logic [VEL_W-1:0] vmag(input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W:0] w;
		w = 17'(v);
		return (w < 0) ? 16'(-w) : 16'(w);
	endfunction

	assign stat.turn_ok = (turn_q >= -14'sd4096) && (turn_q <= 14'sd4096);
	assign speed_zero   = (speed_q == '0);

	assign k_l      = 15'sd4096 - 15'(turn_q);
	assign k_r      = 15'sd4096 + 15'(turn_q);
	assign step_sum = prod_q[32:0] + HALF_MEGA;
	assign step     = prod_q[SHIFT_STEP+STEP_W-1:SHIFT_STEP];

	assign nl = ramp(lt_q, lv_q, step, cfg.settle_band);
	assign nr = ramp(rt_q, rv_q, step, cfg.settle_band);

	always_comb begin
		if (prod_q[54:SHIFT_FREQ] > 23'(FREQ_MAX))
			freq = FREQ_MAX;
		else
			freq = prod_q[SHIFT_FREQ+FREQ_W-1:SHIFT_FREQ];
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_CMD_L: begin
				mul_a = 29'(speed_q);
				mul_b = 29'(k_l);
			end
			MUL_CMD_R: begin
				mul_a = 29'(speed_q);
				mul_b = 29'(k_r);
			end
			MUL_ACC: begin
				mul_a = $signed(29'(cfg.accel_rate));
				mul_b = $signed(29'(el_q));
			end
			MUL_STEP: begin
				mul_a = $signed(29'(step_sum[32:6]));
				mul_b = $signed(29'(RECIP_STEP));
			end
			MUL_SCALE: begin
				mul_a = $signed(29'(cfg.microsteps));
				mul_b = $signed(29'(K_VAL));
			end
			MUL_FREQ_L: begin
				mul_a = $signed(29'(vmag(lv_q)));
				mul_b = $signed(29'(prod_q[CW-1:0]));
			end
			MUL_FREQ_R: begin
				mul_a = $signed(29'(vmag(rv_q)));
				mul_b = $signed(29'(c_q));
			end
			MUL_RECIP: begin
				mul_a = $signed(29'(prod_q[YW+11:12]));
				mul_b = $signed(29'(RECIP_FREQ));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			speed_q <= s_tdata[15:0];
			turn_q  <= s_tdata[29:16];
			el_q    <= s_tdata[45:30];
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.wr_c)
			c_q <= prod_q[CW-1:0];
		if (cmd.wr_lf)
			lf_q <= freq;
		if (cmd.wr_vel) begin
			lupd_q <= (nl != lv_q);
			rupd_q <= (nr != rv_q);
		end
		if (cmd.load_out) begin
			of_lf_q   <= lf_q;
			of_ldir_q <= (lv_q >= 0);
			of_lupd_q <= lupd_q;
			of_rf_q   <= freq;
			of_rdir_q <= !(rv_q > 0);
			of_rupd_q <= rupd_q;
		end
	end

	// wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			rt_q <= '0;
			lv_q <= '0;
			rv_q <= '0;
		end else begin
			if (cmd.wr_lt)
				lt_q <= speed_zero ? 16'(turn_q) : rnd_sat(prod_q);
			if (cmd.wr_rt)
				rt_q <= speed_zero ? 16'(-15'(turn_q)) : rnd_sat(prod_q);
			if (cmd.wr_vel) begin
				lv_q <= nl;
				rv_q <= nr;
			end
		end
	end

	// right_update, right_dir, right_freq, left_update, left_dir, left_freq
	assign m_tdata = {of_rupd_q, of_rdir_q, of_rf_q, of_lupd_q, of_ldir_q, of_lf_q};

endmodule

>>> design/ddvr_ctrl.sv
// ----------------------------------------------------------------------------
// ddvr_ctrl
// Controller: sequences command and tick words through the datapath and holds
// the result handshake.
// ----------------------------------------------------------------------------
module ddvr_ctrl import ddvr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tuser,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD_L,
		S_CMD_R,
		S_CMD_W,
		S_T_ACC,
		S_T_STEP,
		S_T_RAMP,
		S_T_ML,
		S_T_QL,
		S_T_MR,
		S_T_QR,
		S_T_OUT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_ACC;
		case (state_q)
			S_IDLE: cmd.load_in = s_tvalid;
			S_CMD_L: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CMD_L;
			end
			S_CMD_R: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CMD_R;
				cmd.wr_lt   = stat.turn_ok;
			end
			S_CMD_W: cmd.wr_rt = stat.turn_ok;
			S_T_ACC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACC;
			end
			S_T_STEP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_STEP;
			end
			S_T_RAMP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SCALE;
				cmd.wr_vel  = 1'b1;
			end
			S_T_ML: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FREQ_L;
				cmd.wr_c    = 1'b1;
			end
			S_T_QL, S_T_QR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RECIP;
			end
			S_T_MR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FREQ_R;
				cmd.wr_lf   = 1'b1;
			end
			S_T_OUT: cmd.load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= s_tuser ? S_T_ACC : S_CMD_L;
				end
				S_CMD_L:  state_q <= S_CMD_R;
				S_CMD_R:  state_q <= S_CMD_W;
				S_CMD_W:  state_q <= S_IDLE;
				S_T_ACC:  state_q <= S_T_STEP;
				S_T_STEP: state_q <= S_T_RAMP;
				S_T_RAMP: state_q <= S_T_ML;
				S_T_ML:   state_q <= S_T_QL;
				S_T_QL:   state_q <= S_T_MR;
				S_T_MR:   state_q <= S_T_QR;
				S_T_QR:   state_q <= S_T_OUT;
				S_T_OUT: begin
					if (cmd.load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid && s_tuser) |=> (state_q == S_T_ACC))
		else $error("tick word did not start the tick sequence");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T_OUT && m_tvalid_q && !m_tready) |=> (state_q == S_T_OUT))
		else $error("tick finished while result word still pending");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_T_OUT))
		else $error("result word raised outside the final tick step");

	a_busy_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load_in)
		else $error("input word loaded while busy");

endmodule

>>> design/differential_drive_velocity_ramp.sv
// ----------------------------------------------------------------------------
// differential_drive_velocity_ramp
// Two-wheel velocity ramp: speed/turn commands set wheel targets, control
// ticks slew the wheel velocities and report step frequency and direction.
//
//   channel   dir  signals                               carries
//   s_        in   s_tvalid s_tready s_tdata s_tuser     command or tick word
//   m_        out  m_tvalid m_tready m_tdata             one result per tick
//   apb       in   psel penable pwrite paddr pwdata ...  accel, microsteps, band
//
// A command word steps through states CMD_L, CMD_R and CMD_W, its right target
// written in CMD_W; a tick word steps through T_ACC, T_STEP, T_RAMP, T_ML, T_QL,
// T_MR, T_QR and T_OUT, its result registered in T_OUT; the next word is taken
// back in idle, and both sequences are set by the single shared multiplier.
// A new word is accepted while a result waits; a tick stalls in its last step
// only while the previous result is still untaken.
// Reset clears targets, velocities and registers to their defaults at once.
// ----------------------------------------------------------------------------
module differential_drive_velocity_ramp import ddvr_pkg::*; #(
	parameter int unsigned STEPS_PER_TURN = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // speed[15:0], turn[29:16], elapsed_us[45:30], zero
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // left_freq[17:0], left_dir, left_update,
	                               // right_freq[37:20], right_dir, right_update
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	ddvr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddvr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ddvr_dp #(
		.STEPS_PER_TURN (STEPS_PER_TURN)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata)
	);

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-wheel velocity ramp. Command and tick words
// go in on the input stream with random gaps. Each accepted word updates a
// local model of the wheel targets and velocities, and every tick queues the
// wheel report that it should produce. Reports are checked field by field in
// arrival order. The output side stalls at random and holds off once for a
// long stretch, so the input stalls too. The registers are rewritten between
// phases, the extreme settings among them.
// ----------------------------------------------------------------------------
module testbench import ddvr_pkg::*; ();

	localparam int unsigned STEPS_PER_TURN = 200;
	localparam int unsigned FREQ_TOP       = 262143;
	localparam int          DRAIN_CYCLES   = 24;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          PHASE_WORDS    = 250;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam int REG_ACCEL      = 0;
	localparam int REG_MICROSTEPS = 1;
	localparam int REG_BAND       = 2;
	localparam int REG_SPARE      = 3;

	typedef struct {
		logic [FREQ_W-1:0] left_freq;
		logic              left_dir;
		logic              left_update;
		logic [FREQ_W-1:0] right_freq;
		logic              right_dir;
		logic              right_update;
	} wheel_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;    // speed, turn, elapsed_us, zero
	logic        s_tuser = 1'b0;  // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // left_freq, left_dir, left_update,
	                              // right_freq, right_dir, right_update
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	differential_drive_velocity_ramp #(
		.STEPS_PER_TURN(STEPS_PER_TURN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cfg_t                     cfg_now;
	logic signed [VEL_W-1:0]  left_target, right_target;
	logic signed [VEL_W-1:0]  left_cur, right_cur;
	wheel_report_t            report_q[$];
	wheel_report_t            want_r;
	int                       mismatches = 0;
	bit                       tx_calm = 1'b0;

	logic hold_start = 1'b0;
	int   hold_left = 0;
	int   rx_idle = 0;
	bit   rx_calm = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// ---- wheel model ----

	function automatic logic signed [VEL_W-1:0] clip_vel(longint x);
		if (x > 32767) return 16'sh7fff;
		if (x < -32768) return 16'sh8000;
		return x[VEL_W-1:0];
	endfunction

	function automatic int ramp_wheel(int target, int vel, int step);
		int diff;
		int mag;
		diff = target - vel;
		mag = diff < 0 ? -diff : diff;
		if (mag <= int'(cfg_now.settle_band)) return vel;
		if (target > vel) begin
			vel += step;
			if (vel > target) vel = target;
		end else begin
			vel -= step;
			if (vel < target) vel = target;
		end
		return vel;
	endfunction

	function automatic logic [FREQ_W-1:0] wheel_freq(int v);
		longint mag;
		longint f;
		mag = v < 0 ? -v : v;
		f = longint'(STEPS_PER_TURN) * longint'(cfg_now.microsteps) * mag * 100
			/ (21 * 4096);
		if (f > FREQ_TOP) f = FREQ_TOP;
		return f[FREQ_W-1:0];
	endfunction

	task automatic track_word(input logic op, input logic [SPEED_W-1:0] spd,
			input logic [TURN_W-1:0] trn, input logic [EL_W-1:0] el);
		int            s, t, step, nl, nr;
		longint        prod;
		wheel_report_t rep;
		if (op == OP_COMMAND) begin
			s = $signed(spd);
			t = $signed(trn);
			if (t >= -4096 && t <= 4096) begin
				if (s == 0) begin
					left_target = VEL_W'(t);
					right_target = VEL_W'(-t);
				end else begin
					left_target = clip_vel((longint'(s) * (4096 - t) + 2048) >>> 12);
					right_target = clip_vel((longint'(s) * (4096 + t) + 2048) >>> 12);
				end
			end
		end else begin
			prod = longint'(cfg_now.accel_rate) * longint'(el);
			step = int'((prod + 500000) / 1000000);
			nl = ramp_wheel(left_target, left_cur, step);
			nr = ramp_wheel(right_target, right_cur, step);
			rep.left_freq = wheel_freq(nl);
			rep.left_dir = nl >= 0;
			rep.left_update = nl != int'(left_cur);
			rep.right_freq = wheel_freq(nr);
			rep.right_dir = !(nr > 0);
			rep.right_update = nr != int'(right_cur);
			left_cur = VEL_W'(nl);
			right_cur = VEL_W'(nr);
			report_q.push_back(rep);
		end
	endtask

	// ---- output side ----

	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_idle > 0) begin
			rx_idle <= rx_idle - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm) rx_idle <= pick_gap();
		end
	end

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0d, got %0d", what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (report_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word %h with nothing expected", m_tdata);
			end else begin
				want_r = report_q.pop_front();
				check_field("left_freq", want_r.left_freq, m_tdata[17:0]);
				check_field("left_dir", want_r.left_dir, m_tdata[18]);
				check_field("left_update", want_r.left_update, m_tdata[19]);
				check_field("right_freq", want_r.right_freq, m_tdata[37:20]);
				check_field("right_dir", want_r.right_dir, m_tdata[38]);
				check_field("right_update", want_r.right_update, m_tdata[39]);
			end
		end
	end

	// ---- input side and registers ----

	task automatic send_word(input logic op, input logic [SPEED_W-1:0] spd,
			input logic [TURN_W-1:0] trn, input logic [EL_W-1:0] el);
		int gap;
		if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= op;
		s_tdata <= {2'b00, el, trn, spd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		track_word(op, spd, trn, el);
	endtask

	task automatic send_random_word();
		logic [SPEED_W-1:0] spd;
		logic [TURN_W-1:0]  trn;
		logic [EL_W-1:0]    el;
		int                 r;
		spd = $urandom();
		trn = $urandom();
		el = $urandom();
		if ($urandom_range(0, 99) < 25) begin
			r = $urandom_range(0, 99);
			if (r < 10) spd = '0;
			if ($urandom_range(0, 99) < 80) trn = TURN_W'($urandom_range(0, 8192) - 4096);
			send_word(OP_COMMAND, spd, trn, el);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) el = $urandom_range(0, 20000);
			else if (r < 80) el = $urandom_range(0, 100);
			send_word(OP_TICK, spd, trn, el);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ACCEL:      cfg_now.accel_rate = val[ACCEL_W-1:0];
			REG_MICROSTEPS: cfg_now.microsteps = val[MS_W-1:0];
			REG_BAND:       cfg_now.settle_band = val[BAND_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] accel, input logic [31:0] ms,
			input logic [31:0] band);
		wait_idle();
		apb_write(REG_ACCEL, accel);
		apb_write(REG_MICROSTEPS, ms);
		apb_write(REG_BAND, band);
	endtask

	// ---- tests ----

	task automatic test_directed();
		send_word(OP_TICK, '0, '0, 16'd0);
		send_word(OP_COMMAND, 16'sh7fff, 14'd0, '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		send_word(OP_COMMAND, 16'sh8000, 14'd4096, '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		send_word(OP_COMMAND, 16'sh7fff, 14'(-4096), '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		// turns out of range leave the targets alone
		send_word(OP_COMMAND, 16'd1000, 14'd4097, '0);
		send_word(OP_COMMAND, 16'd1000, 14'(-4097), '0);
		send_word(OP_COMMAND, 16'hffff, 14'h1fff, 16'hffff);
		send_word(OP_COMMAND, 16'hffff, 14'h2000, 16'hffff);
		send_word(OP_TICK, 16'hffff, 14'h3fff, 16'd30000);
		// spin on the spot
		send_word(OP_COMMAND, 16'd0, 14'd4096, '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		send_word(OP_COMMAND, 16'd0, 14'(-4096), '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		// half-way rounding
		send_word(OP_COMMAND, 16'd1, 14'd2048, '0);
		send_word(OP_TICK, '0, '0, 16'd1);
		send_word(OP_COMMAND, 16'hffff, 14'd2048, '0);
		send_word(OP_TICK, '0, '0, 16'hffff);
		// back to rest
		send_word(OP_COMMAND, 16'd0, 14'd0, '0);
		repeat (3) send_word(OP_TICK, '0, '0, 16'hffff);
	endtask

	task automatic test_backpressure();
		bit was_calm;
		was_calm = tx_calm;
		tx_calm = 1'b1;
		s_tvalid <= 1'b0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		send_word(OP_COMMAND, 16'sh4000, 14'd1024, '0);
		repeat (40) send_word(OP_TICK, '0, '0, 16'd20000);
		tx_calm = was_calm;
	endtask

	task automatic test_settings_sweep();
		logic [31:0] accel, ms, band;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin accel = 65535; ms = 63; band = 0;   end
				1: begin accel = 0;     ms = 1;  band = 255; end
				2: begin accel = 65535; ms = 0;  band = 0;   end
				3: begin accel = 1;     ms = 32; band = 255; end
				4: begin accel = 4096;  ms = 3;  band = 4;   end
				default: begin
					accel = $urandom();
					ms = $urandom_range(0, 99) < 60 ? 1 << $urandom_range(0, 5) : $urandom();
					band = $urandom();
				end
			endcase
			configure(accel, ms, band);
			if (p == 0) apb_write(REG_SPARE, $urandom());
			repeat (PHASE_WORDS) send_random_word();
		end
	endtask

	initial begin
		cfg_now = '{ACCEL_RST, MS_RST, BAND_RST};
		left_target = '0;
		right_target = '0;
		left_cur = '0;
		right_cur = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_settings_sweep();
		wait_idle();
		if (mismatches == 0 && report_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
design/ddvr_pkg.sv
design/ddvr_regs.sv
design/ddvr_dp.sv
design/ddvr_ctrl.sv
design/differential_drive_velocity_ramp.sv
verif/testbench.sv
